/* hdl/vfc_pkg.sv */
package vfc_pkg;

    // Grid geometry
    localparam int GRID_EDGE = 32;
    localparam int COORD_W   = 5;
    localparam int NB_W      = COORD_W + 2;
    localparam int GRID_CELLS = GRID_EDGE * GRID_EDGE * GRID_EDGE;
    localparam int ADDR_W    = $clog2(GRID_CELLS);

    // Face output
    localparam int VBASE_W    = 20;
    localparam int FACE_VERTS = 4;
    localparam int DIR_W      = 3;
    localparam int NUM_DIRS   = 6;

    // Command queue between front and back end
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [DIR_W-1:0] {
        DIR_POS_X = 3'd0,
        DIR_POS_Y = 3'd1,
        DIR_NEG_X = 3'd2,
        DIR_NEG_Y = 3'd3,
        DIR_POS_Z = 3'd4,
        DIR_NEG_Z = 3'd5
    } face_dir_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_EMIT
    } back_state_t;

    // Classified command handed from front to back end
    typedef struct packed {
        logic               is_query;
        logic               in_grid;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               solid;
        logic [ADDR_W-1:0]  addr;
    } cmd_t;

    // Neighbor coordinate, two's complement, wide enough for -1 and edge+1
    typedef struct packed {
        logic [NB_W-1:0] x;
        logic [NB_W-1:0] y;
        logic [NB_W-1:0] z;
    } nb_coord_t;

    function automatic logic coord_in_grid(input logic [NB_W-1:0] c);
        return (c[NB_W-1] == 1'b0) && (int'(c) < GRID_EDGE);
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [NB_W-1:0] cx,
                                                    input logic [NB_W-1:0] cy,
                                                    input logic [NB_W-1:0] cz);
        return ADDR_W'((int'(cz) * GRID_EDGE + int'(cy)) * GRID_EDGE + int'(cx));
    endfunction

    function automatic nb_coord_t nb_of(input logic [DIR_W-1:0]   dir,
                                        input logic [COORD_W-1:0] x,
                                        input logic [COORD_W-1:0] y,
                                        input logic [COORD_W-1:0] z);
        nb_coord_t nb;
        nb.x = NB_W'(x);
        nb.y = NB_W'(y);
        nb.z = NB_W'(z);
        case (dir)
            DIR_POS_X: nb.x = nb.x + NB_W'(1);
            DIR_POS_Y: nb.y = nb.y + NB_W'(1);
            DIR_NEG_X: nb.x = nb.x - NB_W'(1);
            DIR_NEG_Y: nb.y = nb.y - NB_W'(1);
            DIR_POS_Z: nb.z = nb.z + NB_W'(1);
            DIR_NEG_Z: nb.z = nb.z - NB_W'(1);
            default:   ;
        endcase
        return nb;
    endfunction

endpackage

/* hdl/vfc_front.sv */
module vfc_front
    import vfc_pkg::*;
(
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic [COORD_W-1:0] block_x,
    input  logic [COORD_W-1:0] block_y,
    input  logic [COORD_W-1:0] block_z,
    input  logic               solid,
    input  logic               q_full,
    output logic               q_push,
    output cmd_t               q_cmd
);

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // Decode the word, check bounds and form the cell address up front
    always_comb
    begin
        q_cmd.is_query = (opcode == OP_QUERY);
        q_cmd.in_grid  = coord_in_grid(NB_W'(block_x)) &&
                         coord_in_grid(NB_W'(block_y)) &&
                         coord_in_grid(NB_W'(block_z));
        q_cmd.x        = block_x;
        q_cmd.y        = block_y;
        q_cmd.z        = block_z;
        q_cmd.solid    = solid;
        q_cmd.addr     = cell_addr(NB_W'(block_x), NB_W'(block_y), NB_W'(block_z));
    end

endmodule

/* hdl/vfc_cmd_fifo.sv */
module vfc_cmd_fifo
    import vfc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("command queue popped while empty");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != QCNT_W'(QUEUE_DEPTH))
        else $error("command queue pushed while full");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("command queue count out of range");

endmodule

/* hdl/vfc_back.sv */
module vfc_back
    import vfc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  cmd_t               q_cmd,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [COORD_W-1:0] face_x,
    output logic [COORD_W-1:0] face_y,
    output logic [COORD_W-1:0] face_z,
    output logic [DIR_W-1:0]   face_direction,
    output logic [VBASE_W-1:0] vertex_base,
    output logic               last_face
);

    back_state_t state_reg, state_next;

    logic [COORD_W-1:0]  x_reg, x_next;
    logic [COORD_W-1:0]  y_reg, y_next;
    logic [COORD_W-1:0]  z_reg, z_next;
    logic [DIR_W-1:0]    rd_cnt_reg, rd_cnt_next;
    logic [NUM_DIRS:0]   solid_reg, solid_next;
    logic [NUM_DIRS-1:0] face_reg, face_next;
    logic [VBASE_W-1:0]  vcnt_reg, vcnt_next;

    logic                out_valid_reg, out_valid_next;
    logic [COORD_W-1:0]  fx_reg, fy_reg, fz_reg;
    logic [DIR_W-1:0]    fdir_reg;
    logic [VBASE_W-1:0]  vbase_reg;
    logic                last_reg;

    // Grid memory: one read or write per cycle, registered read
    logic                mem [GRID_CELLS];
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_addr;
    logic                mem_q_reg;

    logic [NUM_DIRS-1:0] nb_in;
    logic [NUM_DIRS-1:0] pick_oh;
    logic [NUM_DIRS-1:0] remain;
    logic [DIR_W-1:0]    pick_dir;
    logic                out_load;
    logic                out_free;
    nb_coord_t           rd_nb;

    assign out_free = !out_valid_reg || out_ready;

    // Which neighbors of the held block lie inside the grid
    always_comb
    begin
        nb_coord_t nb;
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            nb       = nb_of(DIR_W'(d), x_reg, y_reg, z_reg);
            nb_in[d] = coord_in_grid(nb.x) && coord_in_grid(nb.y) && coord_in_grid(nb.z);
        end
    end

    // Lowest pending face goes out first
    always_comb
    begin
        pick_oh  = face_reg & (~face_reg + NUM_DIRS'(1));
        remain   = face_reg & ~pick_oh;
        pick_dir = '0;
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            if (pick_oh[d])
                pick_dir = DIR_W'(d);
        end
    end

    assign rd_nb = nb_of(rd_cnt_reg, x_reg, y_reg, z_reg);

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next  = state_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        z_next      = z_reg;
        rd_cnt_next = rd_cnt_reg;
        solid_next  = solid_reg;
        face_next   = face_reg;
        vcnt_next   = vcnt_reg;
        q_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_addr    = q_cmd.addr;
        out_load    = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (!q_cmd.is_query)
                        mem_we = q_cmd.in_grid;
                    else if (q_cmd.in_grid)
                    begin
                        x_next      = q_cmd.x;
                        y_next      = q_cmd.y;
                        z_next      = q_cmd.z;
                        rd_cnt_next = '0;
                        state_next  = B_READ;
                    end
                end
            end

            B_READ:
            begin
                // Data for entry rd_cnt arrives; fetch neighbor rd_cnt next
                solid_next[rd_cnt_reg] = mem_q_reg;
                mem_addr    = cell_addr(rd_nb.x, rd_nb.y, rd_nb.z);
                rd_cnt_next = rd_cnt_reg + DIR_W'(1);
                if (rd_cnt_reg == DIR_W'(NUM_DIRS))
                begin
                    face_next = solid_next[0] ? ~(solid_next[NUM_DIRS:1] & nb_in) : '0;
                    state_next = (face_next != '0) ? B_EMIT : B_IDLE;
                end
            end

            B_EMIT:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    face_next = remain;
                    vcnt_next = vcnt_reg + VBASE_W'(FACE_VERTS);
                    if (remain == '0)
                        state_next = B_IDLE;
                end
            end

            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            rd_cnt_reg    <= '0;
            face_reg      <= '0;
            vcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_cnt_reg    <= rd_cnt_next;
            face_reg      <= face_next;
            vcnt_reg      <= vcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        solid_reg <= solid_next;
        if (out_load)
        begin
            fx_reg    <= x_reg;
            fy_reg    <= y_reg;
            fz_reg    <= z_reg;
            fdir_reg  <= pick_dir;
            vbase_reg <= vcnt_reg;
            last_reg  <= (remain == '0);
        end
    end

    // Grid memory port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= q_cmd.solid;
        mem_q_reg <= mem[mem_addr];
    end

    assign out_valid      = out_valid_reg;
    assign face_x         = fx_reg;
    assign face_y         = fy_reg;
    assign face_z         = fz_reg;
    assign face_direction = fdir_reg;
    assign vertex_base    = vbase_reg;
    assign last_face      = last_reg;

    a_rd_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_READ |-> rd_cnt_reg <= DIR_W'(NUM_DIRS))
        else $error("read sequencer ran past the last neighbor");

    a_face_needs_solid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> solid_reg[0])
        else $error("face emitted for an air block");

    a_last_ends_query: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && remain == '0) |=> state_reg == B_IDLE)
        else $error("sequencer kept emitting after the last face");

    a_vcnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> vcnt_reg == $past(vcnt_reg) + VBASE_W'(FACE_VERTS))
        else $error("vertex base did not advance by one face");

endmodule

/* hdl/voxel_face_culler.sv */
// Voxel face culler.
// Input channel (in_valid/in_ready) carries one word per operation: opcode 0
// stores the solid bit of block (block_x, block_y, block_z); opcode 1 queries
// that block. A solid queried block yields one output word per exposed face
// (neighbor air or outside the grid) in the order +x, +y, -x, -y, +z, -z,
// each with the running vertex base (advancing by 4, wrapping at 2^20);
// last_face marks the final face of the query. Air or out-of-grid blocks and
// writes yield nothing.
// Words enter a four-entry command queue; in_ready drops only when it is full.
// The back end retires a write at once, and a query by grid reads (center
// plus six neighbors through the single grid memory port, one after the
// other) followed by one face per cycle while the output is free; with an
// idle back end the first face is offered once those reads are done. The
// grid memory port sets the pace of those reads.
// When out_ready is low the face stays in the output register and the back
// end holds; the queue keeps taking words until full.
// Reset clears the queue, the sequencer and the vertex base to zero. Grid
// contents are not cleared: a block must be written before it (or a
// neighbor of a queried block) is read.
module voxel_face_culler
    import vfc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic [COORD_W-1:0] block_x,
    input  logic [COORD_W-1:0] block_y,
    input  logic [COORD_W-1:0] block_z,
    input  logic               solid,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [COORD_W-1:0] face_x,
    output logic [COORD_W-1:0] face_y,
    output logic [COORD_W-1:0] face_z,
    output logic [DIR_W-1:0]   face_direction,
    output logic [VBASE_W-1:0] vertex_base,
    output logic               last_face
);

    logic q_full;
    logic q_push;
    cmd_t q_in_cmd;
    logic q_pop;
    logic q_valid;
    cmd_t q_head;

    vfc_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .opcode   (opcode),
        .block_x  (block_x),
        .block_y  (block_y),
        .block_z  (block_z),
        .solid    (solid),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_in_cmd)
    );

    vfc_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_in_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head)
    );

    vfc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_cmd          (q_head),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .face_x         (face_x),
        .face_y         (face_y),
        .face_z         (face_z),
        .face_direction (face_direction),
        .vertex_base    (vertex_base),
        .last_face      (last_face)
    );

endmodule

/* sim/voxel_face_culler_test.sv */
module voxel_face_culler_test;
    import vfc_pkg::*;

    // One word for the input channel, or a marker that holds the sender
    // until every face predicted so far has come out
    typedef struct {
        bit                 drain;
        logic               op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               s;
    } block_word_t;

    typedef struct {
        logic [COORD_W-1:0] fx;
        logic [COORD_W-1:0] fy;
        logic [COORD_W-1:0] fz;
        face_dir_t          dir;
        logic [VBASE_W-1:0] vbase;
        logic               last;
    } face_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               opcode = OP_WRITE;
    logic [COORD_W-1:0] block_x = '0;
    logic [COORD_W-1:0] block_y = '0;
    logic [COORD_W-1:0] block_z = '0;
    logic               solid = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [COORD_W-1:0] face_x;
    logic [COORD_W-1:0] face_y;
    logic [COORD_W-1:0] face_z;
    logic [DIR_W-1:0]   face_direction;
    logic [VBASE_W-1:0] vertex_base;
    logic               last_face;

    // Stimulus side
    block_word_t pending_words[$];
    block_word_t next_word;
    bit          written [GRID_CELLS];
    bit          planned_solid [GRID_CELLS];
    int          words_planned = 0;
    int          solid_queries = 0;
    int          prev_x = 16;
    int          prev_y = 16;
    int          prev_z = 16;
    int          words_sent = 0;

    // Predicted grid, vertex base and face stream
    bit                 model_grid [GRID_CELLS];
    logic [VBASE_W-1:0] vertex_count = '0;
    face_t              faces_due[$];
    face_t              face_exp;
    int                 faces_made = 0;
    int                 faces_got = 0;
    int                 mismatches = 0;

    // Receiver hold-off
    int hold_left = 0;
    bit hold_done = 1'b0;

    voxel_face_culler dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .block_x        (block_x),
        .block_y        (block_y),
        .block_z        (block_z),
        .solid          (solid),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .face_x         (face_x),
        .face_y         (face_y),
        .face_z         (face_z),
        .face_direction (face_direction),
        .vertex_base    (vertex_base),
        .last_face      (last_face)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int cell_of(int x, int y, int z);
        return (z * GRID_EDGE + y) * GRID_EDGE + x;
    endfunction

    // Grid index of the neighbor across face d, or -1 outside the grid
    function automatic int nb_index(face_dir_t d, int x, int y, int z);
        int nx;
        int ny;
        int nz;
        nx = x;
        ny = y;
        nz = z;
        case (d)
            DIR_POS_X: nx = x + 1;
            DIR_POS_Y: ny = y + 1;
            DIR_NEG_X: nx = x - 1;
            DIR_NEG_Y: ny = y - 1;
            DIR_POS_Z: nz = z + 1;
            DIR_NEG_Z: nz = z - 1;
            default:   ;
        endcase
        if (nx < 0 || ny < 0 || nz < 0 || nx >= GRID_EDGE || ny >= GRID_EDGE
            || nz >= GRID_EDGE)
            return -1;
        return cell_of(nx, ny, nz);
    endfunction

    // A query reads the block and its neighbors: all must have been written
    function automatic bit can_query(int x, int y, int z);
        int n;
        if (!written[cell_of(x, y, z)])
            return 1'b0;
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            n = nb_index(face_dir_t'(d), x, y, z);
            if (n >= 0 && !written[n])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Mostly near the last cluster, sometimes at a grid face, sometimes anywhere
    function automatic int pick_coord(int prev);
        int v;
        case ($urandom_range(3))
            0: return $urandom_range(1) ? GRID_EDGE - 1 : 0;
            1: return $urandom_range(GRID_EDGE - 1);
            default:
            begin
                v = prev + $urandom_range(2) - 1;
                if (v < 0)
                    v = 0;
                if (v > GRID_EDGE - 1)
                    v = GRID_EDGE - 1;
                return v;
            end
        endcase
    endfunction

    task automatic push_word(input logic op, input int x, input int y, input int z,
                             input logic s);
        block_word_t w;
        w.drain = 1'b0;
        w.op    = op;
        w.x     = COORD_W'(x);
        w.y     = COORD_W'(y);
        w.z     = COORD_W'(z);
        w.s     = s;
        pending_words.push_back(w);
        words_planned++;
        if (op == OP_WRITE)
        begin
            written[cell_of(x, y, z)]       = 1'b1;
            planned_solid[cell_of(x, y, z)] = s;
        end
        else if (planned_solid[cell_of(x, y, z)])
            solid_queries++;
    endtask

    task automatic push_drain();
        block_word_t w;
        w = '{1'b1, OP_WRITE, '0, '0, '0, 1'b0};
        pending_words.push_back(w);
    endtask

    // Block plus its neighbors written with random solidity, then queries
    task automatic add_cluster();
        int n;
        prev_x = pick_coord(prev_x);
        prev_y = pick_coord(prev_y);
        prev_z = pick_coord(prev_z);
        push_word(OP_WRITE, prev_x, prev_y, prev_z, $urandom_range(99) < 85);
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            n = nb_index(face_dir_t'(d), prev_x, prev_y, prev_z);
            if (n >= 0 && (!written[n] || $urandom_range(3) == 0))
                push_word(OP_WRITE, n % GRID_EDGE, (n / GRID_EDGE) % GRID_EDGE,
                          n / (GRID_EDGE * GRID_EDGE), $urandom_range(1));
        end
        // a cluster now and then goes unqueried
        if ($urandom_range(9) != 0)
            push_word(OP_QUERY, prev_x, prev_y, prev_z, $urandom_range(1));
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            n = nb_index(face_dir_t'(d), prev_x, prev_y, prev_z);
            if (n >= 0 && $urandom_range(3) == 0
                && can_query(n % GRID_EDGE, (n / GRID_EDGE) % GRID_EDGE,
                             n / (GRID_EDGE * GRID_EDGE)))
                push_word(OP_QUERY, n % GRID_EDGE, (n / GRID_EDGE) % GRID_EDGE,
                          n / (GRID_EDGE * GRID_EDGE), $urandom_range(1));
        end
    endtask

    // Expected faces of one accepted word
    task automatic predict_faces(input logic op, input logic [COORD_W-1:0] x,
                                 input logic [COORD_W-1:0] y,
                                 input logic [COORD_W-1:0] z, input logic s);
        face_t f;
        int    n;
        int    exposed;
        int    k;
        bit    open_side [NUM_DIRS];
        if (op == OP_WRITE)
        begin
            model_grid[cell_of(x, y, z)] = s;
            return;
        end
        if (!model_grid[cell_of(x, y, z)])
            return;
        exposed = 0;
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            n = nb_index(face_dir_t'(d), x, y, z);
            open_side[d] = (n < 0) || !model_grid[n];
            if (open_side[d])
                exposed++;
        end
        k = 0;
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            if (open_side[d])
            begin
                k++;
                f.fx    = x;
                f.fy    = y;
                f.fz    = z;
                f.dir   = face_dir_t'(d);
                f.vbase = vertex_count;
                f.last  = (k == exposed);
                faces_due.push_back(f);
                vertex_count = vertex_count + VBASE_W'(FACE_VERTS);
                faces_made++;
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        if (mismatches < 50)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // Driver: next word goes out once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_faces(opcode, block_x, block_y, block_z, solid);
            if (!in_valid || in_ready)
            begin
                if (pending_words.size() != 0 && pending_words[0].drain)
                begin
                    if (faces_made == faces_got)
                        void'(pending_words.pop_front());
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() != 0
                         && ((words_sent >= 50 && words_sent < 90)
                             || $urandom_range(99) >= 16))
                begin
                    next_word = pending_words.pop_front();
                    in_valid   <= 1'b1;
                    opcode     <= next_word.op;
                    block_x    <= next_word.x;
                    block_y    <= next_word.y;
                    block_z    <= next_word.z;
                    solid      <= next_word.s;
                    words_sent <= words_sent + 1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, one long hold-off, a stretch with none
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && faces_got >= 15)
        begin
            hold_done <= 1'b1;
            hold_left <= 150;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= (faces_got >= 20 && faces_got < 45) || $urandom_range(99) >= 16;
        end
    end

    // Monitor: each face word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (faces_due.size() == 0)
            begin
                report_mismatch($sformatf("face (%0d,%0d,%0d) dir %0d with none expected",
                                          face_x, face_y, face_z, face_direction));
            end
            else
            begin
                face_exp = faces_due.pop_front();
                if (face_x !== face_exp.fx)
                    report_mismatch($sformatf("face_x %0d, want %0d", face_x, face_exp.fx));
                if (face_y !== face_exp.fy)
                    report_mismatch($sformatf("face_y %0d, want %0d", face_y, face_exp.fy));
                if (face_z !== face_exp.fz)
                    report_mismatch($sformatf("face_z %0d, want %0d", face_z, face_exp.fz));
                if (face_direction !== face_exp.dir)
                    report_mismatch($sformatf("face_direction %0d, want %0d",
                                              face_direction, face_exp.dir));
                if (vertex_base !== face_exp.vbase)
                    report_mismatch($sformatf("vertex_base %0d, want %0d",
                                              vertex_base, face_exp.vbase));
                if (last_face !== face_exp.last)
                    report_mismatch($sformatf("last_face %0b, want %0b",
                                              last_face, face_exp.last));
            end
            faces_got <= faces_got + 1;
        end
    end

    initial
    begin
        #800000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int r;
        int qx;
        int qy;
        int qz;

        // Origin corner, all neighbors air or outside: six faces
        push_word(OP_WRITE, 0, 0, 0, 1'b1);
        push_word(OP_WRITE, 1, 0, 0, 1'b0);
        push_word(OP_WRITE, 0, 1, 0, 1'b0);
        push_word(OP_WRITE, 0, 0, 1, 1'b0);
        push_word(OP_QUERY, 0, 0, 0, 1'b0);
        // Far corner, inner neighbors solid: only the outward faces
        push_word(OP_WRITE, 31, 31, 31, 1'b1);
        push_word(OP_WRITE, 30, 31, 31, 1'b1);
        push_word(OP_WRITE, 31, 30, 31, 1'b1);
        push_word(OP_WRITE, 31, 31, 30, 1'b1);
        push_word(OP_QUERY, 31, 31, 31, 1'b1);
        // Same block cleared to air: no faces
        push_word(OP_WRITE, 31, 31, 31, 1'b0);
        push_word(OP_QUERY, 31, 31, 31, 1'b1);
        // Solid block fully enclosed: no faces, vertex base unchanged
        push_word(OP_WRITE, 16, 16, 16, 1'b1);
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            r = nb_index(face_dir_t'(d), 16, 16, 16);
            push_word(OP_WRITE, r % GRID_EDGE, (r / GRID_EDGE) % GRID_EDGE,
                      r / (GRID_EDGE * GRID_EDGE), 1'b1);
        end
        push_word(OP_QUERY, 16, 16, 16, 1'b0);
        push_word(OP_QUERY, 0, 0, 0, 1'b1);
        push_drain();

        // Random part: mostly clusters, some stray writes and queries
        while (words_planned < 125 || solid_queries < 12)
        begin
            r = $urandom_range(99);
            if (r < 15)
            begin
                push_word(OP_WRITE, $urandom_range(31), $urandom_range(31),
                          $urandom_range(31), $urandom_range(1));
            end
            else if (r < 25)
            begin
                for (int t = 0; t < 8; t++)
                begin
                    qx = $urandom_range(31);
                    qy = $urandom_range(31);
                    qz = $urandom_range(31);
                    if (can_query(qx, qy, qz))
                    begin
                        push_word(OP_QUERY, qx, qy, qz, $urandom_range(1));
                        break;
                    end
                end
            end
            else
            begin
                add_cluster();
            end
            if ($urandom_range(30) == 0)
                push_drain();
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || in_valid)
            @(posedge clk);
        while (faces_made != faces_got)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && faces_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
hdl/vfc_pkg.sv
hdl/vfc_front.sv
hdl/vfc_cmd_fifo.sv
hdl/vfc_back.sv
hdl/voxel_face_culler.sv
sim/voxel_face_culler_test.sv
